@@ sv/dsmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc_pkg
// Shared constants and types for the digit-sum multiple counter.
// ----------------------------------------------------------------------------
package dsmc_pkg;

  localparam int DIG_W = 4;   // digit field
  localparam int DIV_W = 8;   // divisor register
  localparam int CNT_W = 30;  // count field and table entries
  localparam int RADIX = 10;

  localparam logic [CNT_W-1:0] MODULUS = 30'd1000000007;

  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for a digit
    ST_REMT,   // reducing the tight residue by the divisor
    ST_SWEEP,  // issuing table reads
    ST_DRAIN   // pipeline empties, result is posted
  } dsmc_state_t;

endpackage : dsmc_pkg
`default_nettype wire

@@ sv/dsmc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dsmc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 128
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : dsmc_ram
`default_nettype wire

@@ sv/dsmc_rem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsmc_rem
// Restoring remainder unit: one dividend bit per cycle, all NW bits per start.
// ----------------------------------------------------------------------------
module dsmc_rem #(
  parameter int NW  = 8,  // dividend width
  parameter int DVW = 8   // divisor width
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                busy,
  output logic      [DVW-1:0] rem
);

  localparam int SW = $clog2(NW + 1);

  logic [SW-1:0]  step_r;
  logic [NW-1:0]  shift_r;
  logic [DVW-1:0] rem_r;
  logic [DVW:0]   partial;

  assign partial = {rem_r, shift_r[NW-1]};
  assign busy    = (step_r != '0);
  assign rem     = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= SW'(NW);
    end else if (busy) begin
      step_r <= step_r - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= '0;
      shift_r <= dividend;
    end else if (busy) begin
      shift_r <= shift_r << 1;
      if (partial >= {1'b0, divisor}) begin
        rem_r <= DVW'(partial - {1'b0, divisor});
      end else begin
        rem_r <= partial[DVW-1:0];
      end
    end
  end

endmodule : dsmc_rem
`default_nettype wire

@@ sv/digit_sum_multiple_counter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// digit_sum_multiple_counter_core
// Counts integers 1..P with digit sum divisible by D, P fed in digit by digit.
//
// Usage:
//   in_digit/in_first arrive on a valid/ready channel, most significant digit
//   first; in_first starts a new bound. For every digit one out_count is
//   posted on the out channel: how many integers from 1 to the prefix seen so
//   far have a digit sum divisible by D, modulo 1000000007.
//   D is written through cfg_we/cfg_wdata while the block is idle; 0 acts
//   as 1 and values above MAX_DIVISOR saturate.
//   Per digit: the tight residue is reduced in the remainder unit (one bit a
//   cycle), then the residue table in RAM is swept with D + 9 reads, one a
//   cycle, feeding a ten-tap sliding sum; results are written back in place
//   at the end of the pipeline, behind the reads. Between digit transfers the
//   block reduces the residue, sweeps the table, drains the pipeline, posts
//   the result and returns to idle. The single RAM read port sets the rate.
//   in_ready is high only between digits. The result sits in an output
//   register, so the next digit may be taken while it waits; a stalled
//   receiver holds the following digit at the end of its sweep.
//   Reset (and in_first) empty the table through a fill count: no clearing
//   pass, the block is ready in the first cycle after reset. D resets to 1.
// ----------------------------------------------------------------------------
module digit_sum_multiple_counter_core
  import dsmc_pkg::*;
#(
  parameter int MAX_DIVISOR = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [DIG_W-1:0] in_digit,
  input  wire logic             in_first,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [CNT_W-1:0] out_count,
  input  wire logic             cfg_we,
  input  wire logic [DIV_W-1:0] cfg_wdata
);

  localparam int DMAX = (MAX_DIVISOR < 255) ? MAX_DIVISOR : 255;
  localparam int RW   = (DMAX > 1) ? $clog2(DMAX) : 1;        // residue / index
  localparam int DVW  = $clog2(DMAX + 1);                     // divisor value
  localparam int NW   = $clog2(DMAX + 15);                    // t + digit
  localparam int CW   = $clog2(DMAX + 10);                    // read counter
  localparam int AW   = (MAX_DIVISOR > 1) ? $clog2(MAX_DIVISOR) : 1;
  localparam int PRE  = RADIX - 1;                            // prologue reads

  function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      mod_add = CNT_W'(s - {1'b0, MODULUS});
    end else begin
      mod_add = s[CNT_W-1:0];
    end
  endfunction

  function automatic logic [CNT_W-1:0] mod_sub(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    if (a >= b) begin
      mod_sub = a - b;
    end else begin
      mod_sub = CNT_W'({1'b0, a} + {1'b0, MODULUS} - {1'b0, b});
    end
  endfunction

  // nine modulo d, for the first read index of the window
  function automatic logic [DIG_W-1:0] nine_mod(input logic [DIV_W-1:0] d);
    logic [DIG_W-1:0] r;
    unique case (d)
      8'd1:    r = 4'd0;
      8'd2:    r = 4'd1;
      8'd3:    r = 4'd0;
      8'd4:    r = 4'd1;
      8'd5:    r = 4'd4;
      8'd6:    r = 4'd3;
      8'd7:    r = 4'd2;
      8'd8:    r = 4'd1;
      8'd9:    r = 4'd0;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [DIG_W-1:0] pop10(input logic [RADIX-1:0] v);
    logic [DIG_W-1:0] c;
    c = '0;
    for (int i = 0; i < RADIX; i++) begin
      c = c + DIG_W'(v[i]);
    end
    return c;
  endfunction

  dsmc_state_t state_r, state_nxt;

  logic [DIV_W-1:0] cfg_div_r;
  logic [DVW-1:0]   dv;
  logic [DIV_W-1:0] dv8;
  logic [DIV_W-1:0] start8;
  logic [DIG_W-1:0] r9;

  logic [DIG_W-1:0] digit_r;
  logic [DVW-1:0]   ext_r;       // entries at and above this read as zero
  logic [RW-1:0]    tight_r;
  logic [RW-1:0]    t_r;

  logic             rem_start;
  logic [NW-1:0]    rem_dividend;
  logic             rem_busy;
  logic [DVW-1:0]   rem_val;

  logic             accept;
  logic             issue;
  logic             fin;
  logic             pipe_busy;

  logic [CW-1:0]    cnt_r;
  logic [RW-1:0]    rd_idx_r;
  logic [RW-1:0]    rd_idx_inc;

  logic             s1_v_r, s1_main_r, s1_ind_r, s1_zero_r;
  logic [RW-1:0]    s1_idx_r;
  logic             s2_v_r, s2_main_r;
  logic [RW-1:0]    s2_idx_r;
  logic             s3_v_r, s3_main_r;
  logic [RW-1:0]    s3_idx_r;

  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] rd_val;
  logic [CNT_W-1:0] taps_r [RADIX];
  logic [RADIX-1:0] ind_r;
  logic [RADIX-1:0] tmask;
  logic [CNT_W-1:0] diff_r;
  logic [CNT_W-1:0] sum_r;
  logic [DIG_W-1:0] tcnt_r;
  logic [CNT_W-1:0] wdata;
  logic             ram_we;
  logic [CNT_W-1:0] n0_r;
  logic [CNT_W-1:0] result;

  logic             out_valid_r;
  logic [CNT_W-1:0] out_count_r;

  // effective divisor
  always_comb begin
    if (cfg_div_r == '0) begin
      dv = DVW'(1);
    end else if (int'(cfg_div_r) > DMAX) begin
      dv = DVW'(DMAX);
    end else begin
      dv = DVW'(cfg_div_r);
    end
  end

  assign dv8    = DIV_W'(dv);
  assign r9     = nine_mod(dv8);
  assign start8 = (r9 == '0) ? '0 : dv8 - DIV_W'(r9);

  assign rd_idx_inc = (DVW'(rd_idx_r) + DVW'(1) == dv) ? '0 : rd_idx_r + RW'(1);

  // digits below the current one, capped at ten, leave the tight path
  always_comb begin
    for (int n = 0; n < RADIX; n++) begin
      tmask[n] = (DIG_W'(n) < digit_r);
    end
  end

  assign pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign accept    = in_valid && in_ready;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_REMT;
      ST_REMT:  if (!rem_busy) state_nxt = ST_SWEEP;
      ST_SWEEP: if (cnt_r == CW'(int'(dv) + PRE - 1)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (fin) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    rem_start    = 1'b0;
    rem_dividend = '0;
    issue        = 1'b0;
    fin          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        rem_start    = in_valid;
        rem_dividend = in_first ? '0 : NW'(tight_r);
      end
      ST_REMT: begin
        rem_start    = !rem_busy;
        rem_dividend = NW'(RW'(rem_val)) + NW'(digit_r);
      end
      ST_SWEEP: begin
        issue = 1'b1;
      end
      ST_DRAIN: begin
        fin = !pipe_busy && !rem_busy && (!out_valid_r || out_ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_div_r   <= DIV_W'(1);
      ext_r       <= '0;
      tight_r     <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_div_r <= cfg_wdata;
      end
      if (accept && in_first) begin
        ext_r   <= '0;
        tight_r <= '0;
      end
      if (fin) begin
        ext_r   <= dv;
        tight_r <= RW'(rem_val);
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      digit_r <= in_digit;
    end

    if (state_r == ST_REMT && !rem_busy) begin
      t_r      <= RW'(rem_val);
      cnt_r    <= '0;
      rd_idx_r <= RW'(start8);
      sum_r    <= '0;
      ind_r    <= '0;
      for (int i = 0; i < RADIX; i++) begin
        taps_r[i] <= '0;
      end
    end else begin
      if (issue) begin
        cnt_r    <= cnt_r + CW'(1);
        rd_idx_r <= rd_idx_inc;
      end
      // stage 1: shift the window, difference of entering and leaving value
      if (s1_v_r) begin
        taps_r[0] <= rd_val;
        for (int i = 1; i < RADIX; i++) begin
          taps_r[i] <= taps_r[i-1];
        end
        ind_r  <= {ind_r[RADIX-2:0], s1_ind_r};
        diff_r <= mod_sub(rd_val, taps_r[RADIX-1]);
      end
      // stage 2: running window sum and tight-path hits
      if (s2_v_r) begin
        sum_r  <= mod_add(sum_r, diff_r);
        tcnt_r <= pop10(ind_r & tmask);
      end
    end

    s1_main_r <= (int'(cnt_r) >= PRE);
    s1_idx_r  <= rd_idx_r;
    s1_ind_r  <= (rd_idx_r == t_r);
    s1_zero_r <= (DVW'(rd_idx_r) >= ext_r);
    s2_main_r <= s1_main_r;
    s2_idx_r  <= s1_idx_r;
    s3_main_r <= s2_main_r;
    s3_idx_r  <= s2_idx_r;

    // stage 3: write back, keep residue zero for the result
    if (ram_we && s3_idx_r == '0) begin
      n0_r <= wdata;
    end

    if (fin) begin
      out_count_r <= result;
    end
  end

  assign rd_val = s1_zero_r ? '0 : rd_data;
  assign wdata  = mod_add(sum_r, CNT_W'(tcnt_r));
  assign ram_we = s3_v_r && s3_main_r;

  // value zero is not counted
  always_comb begin
    if (rem_val == '0) begin
      result = n0_r;
    end else if (n0_r == '0) begin
      result = MODULUS - CNT_W'(1);
    end else begin
      result = n0_r - CNT_W'(1);
    end
  end

  dsmc_rem #(
    .NW  (NW),
    .DVW (DVW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (dv),
    .busy     (rem_busy),
    .rem      (rem_val)
  );

  dsmc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_DIVISOR)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(s3_idx_r)),
    .wdata (wdata),
    .re    (issue),
    .raddr (AW'(rd_idx_r)),
    .rdata (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  // ---------------------------------------------------------------- checks
  a_we_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("table write outside a sweep");

  a_we_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (DVW'(s3_idx_r) < dv))
    else $error("table write beyond divisor");

  a_out_mod: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count < MODULUS))
    else $error("result not reduced");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == ST_DRAIN && !$past(pipe_busy)))
    else $error("result posted before sweep finished");

endmodule : digit_sum_multiple_counter_core
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for digit_sum_multiple_counter_core. Bounds are fed
// digit by digit over the input channel with random idling on both sides.
// A residue-table predictor computes the expected count per digit, and the
// output monitor checks the counts in order. The divisor is reprogrammed
// between phases, at its extremes and in mid-bound.
// ----------------------------------------------------------------------------
module tb_top;
  import dsmc_pkg::*;

  localparam int MAXD = 128;
  localparam int RAND_ITEMS = 1750;
  localparam int HOLD_CYCLES = 1200;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam logic [63:0] MOD64 = 64'(MODULUS);

  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             first;
  } digit_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [DIG_W-1:0] in_digit = '0;
  logic             in_first = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CNT_W-1:0] out_count;
  logic             cfg_we = 1'b0;
  logic [DIV_W-1:0] cfg_wdata = '0;

  logic steady = 1'b0;    // no idling on either side
  logic hold_req = 1'b0;  // starts a long receiver hold-off
  int   hold_left = 0;

  digit_item_t      digit_q [$];
  logic [CNT_W-1:0] count_q [$];

  // predictor state
  logic [DIV_W-1:0] div_reg = 8'd1;
  logic [CNT_W-1:0] below_cnt [MAXD] = '{default: '0};
  int               tight_res = 0;

  int     errors = 0;
  int     digits_in = 0;
  int     counts_out = 0;
  int     bounds = 0;
  int     div_writes = 0;
  longint cycles = 0;

  digit_sum_multiple_counter_core #(
    .MAX_DIVISOR(MAXD)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_digit (in_digit),
    .in_first (in_first),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_count(out_count),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Advances the residue table by one digit and returns the count for the
  // new prefix, value zero excluded.
  function automatic logic [CNT_W-1:0] next_digit_count(input logic [DIG_W-1:0] dig,
                                                        input logic first_f);
    logic [63:0] acc [MAXD];
    logic [63:0] tot;
    int dv;
    int t;
    int r;
    int n;
    dv = int'(div_reg);
    if (dv == 0) dv = 1;
    if (dv > MAXD) dv = MAXD;
    if (first_f) begin
      foreach (below_cnt[i]) below_cnt[i] = '0;
      tight_res = 0;
    end
    t = tight_res % dv;
    foreach (acc[i]) acc[i] = '0;
    for (r = 0; r < dv; r++) begin
      for (n = 0; n < RADIX; n++) begin
        acc[(r + n) % dv] += 64'(below_cnt[r]);
      end
    end
    // tight prefix drops below for every digit smaller than this one
    for (n = 0; n < RADIX && n < int'(dig); n++) begin
      acc[(t + n) % dv] += 64'd1;
    end
    for (r = 0; r < MAXD; r++) begin
      below_cnt[r] = (r < dv) ? CNT_W'(acc[r] % MOD64) : '0;
    end
    tight_res = (t + int'(dig)) % dv;
    tot = 64'(below_cnt[0]) + ((tight_res == 0) ? 64'd1 : 64'd0);
    tot = (tot + MOD64 - 64'd1) % MOD64;
    return tot[CNT_W-1:0];
  endfunction

  // sender
  always @(posedge clk) begin
    digit_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (digit_q.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
        it = digit_q.pop_front();
        in_valid <= 1'b1;
        in_digit <= it.digit;
        in_first <= it.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_ready <= rst_n && !hold_req && hold_left == 0 &&
                 (steady || $urandom_range(0, 99) >= 24);
  end

  // monitor: result check first, then prediction for a new digit transfer
  always @(posedge clk) begin
    logic [CNT_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        counts_out++;
        if (count_q.size() == 0) begin
          report_mismatch($sformatf("count %0d with no digit pending", out_count));
        end else begin
          want = count_q.pop_front();
          if (out_count !== want) begin
            report_mismatch($sformatf("count %0d, expected %0d (result %0d)",
                                      out_count, want, counts_out));
          end
        end
      end
      if (in_valid && in_ready) begin
        digits_in++;
        count_q.push_back(next_digit_count(in_digit, in_first));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d counts outstanding", cycles, count_q.size());
      $display("digit_sum_multiple_counter_core verification failed");
      $finish;
    end
  end

  task automatic push_item(input int d, input bit f);
    digit_item_t it;
    it.digit = d[DIG_W-1:0];
    it.first = f;
    digit_q.push_back(it);
  endtask

  function automatic int rand_digit();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
  endfunction

  function automatic int pick_divisor();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return MAXD;
      3: return $urandom_range(MAXD + 1, 255);
      default: return $urandom_range(2, MAXD - 1);
    endcase
  endfunction

  // Queues whole bounds (first flag on the leading digit) plus some loose
  // digits with random flags. With cont set the first bound extends the
  // previous one.
  task automatic push_bounds(input int n_items, input bit cont, output int pushed);
    int len;
    int i;
    int sel;
    bit lead;
    pushed = 0;
    lead = !cont;
    while (pushed < n_items) begin
      sel = $urandom_range(0, 19);
      if (sel <= 13) begin
        len = $urandom_range(1, 12);
      end else if (sel <= 17) begin
        len = $urandom_range(13, 40);
      end else begin
        len = 0;
      end
      if (len == 0) begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) push_item($urandom_range(0, 15), $urandom_range(0, 2) == 0);
      end else begin
        for (i = 0; i < len; i++) push_item(rand_digit(), i == 0 && lead);
        bounds++;
      end
      lead = 1'b1;
      pushed += len;
    end
  endtask

  // Waits at falling edges until every digit is transferred and counted.
  task automatic drain();
    do @(negedge clk); while (digit_q.size() != 0 || in_valid || count_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_divisor(input logic [DIV_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    div_reg = v;
    div_writes++;
    @(negedge clk);
  endtask

  initial begin
    int p;
    int n;
    int rnd_items;
    bit cont;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset divisor, no start flag yet, digits above nine
    push_item(5, 0); push_item(0, 0); push_item(9, 0); push_item(15, 0);
    drain();
    write_divisor(8'd0);
    push_item(9, 1); push_item(10, 0); push_item(0, 0);
    drain();
    write_divisor(8'd255);
    push_item(9, 1); push_item(9, 0); push_item(9, 0); push_item(12, 0);
    drain();
    write_divisor(DIV_W'(MAXD));
    push_item(1, 1); push_item(0, 0); push_item(0, 0);
    drain();
    // shrink the divisor in mid-bound: upper table entries must drop out
    write_divisor(8'd7);
    push_item(3, 0); push_item(9, 0);
    drain();
    write_divisor(DIV_W'(MAXD + 1));
    push_item(0, 1); push_item(7, 0);
    drain();
    write_divisor(8'd3);
    push_item(0, 1); push_item(0, 0); push_item(1, 0); push_item(11, 0);
    push_item(14, 0); push_item(13, 0); push_item(9, 0);
    drain();

    rnd_items = 0;
    p = 0;
    while (rnd_items < RAND_ITEMS) begin
      write_divisor(DIV_W'(pick_divisor()));
      cont = ($urandom_range(0, 3) == 0);
      steady <= (p == 4);
      push_bounds($urandom_range(40, 140), cont, n);
      rnd_items += n;
      if (p == 2 || p == 9) begin
        // receiver backs off while the sender keeps offering digits
        hold_req <= 1'b1;
        @(negedge clk);
        hold_req <= 1'b0;
      end
      drain();
      p++;
    end

    repeat (40) @(posedge clk);
    if (count_q.size() != 0) begin
      report_mismatch($sformatf("%0d counts never arrived", count_q.size()));
    end
    $display("Checked %0d counts from %0d digit transfers in %0d bounds, %0d phases.",
             counts_out, digits_in, bounds, p + 7);
    $display("Divisor written %0d times incl. 0, 1, 128, saturating and mid-bound values.",
             div_writes);
    if (errors == 0) begin
      $display("digit_sum_multiple_counter_core verification clean");
    end else begin
      $display("digit_sum_multiple_counter_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dsmc_pkg.sv
sv/dsmc_ram.sv
sv/dsmc_rem.sv
sv/digit_sum_multiple_counter_core.sv
tb/sv/tb_top.sv
